>>> src/gdad_pkg.sv
`default_nettype none

package gdad_pkg;

    // Calendar limits
    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [4:0]  DAY_FIRST = 5'd1;
    localparam logic [4:0]  DAY_LAST_DEC = 5'd31;

    // Year split into century and year-of-century: q = (y * 5243) >> 19
    // gives y / 100 exactly for every year up to the limit.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [6:0]  CENT_LAST   = 7'd99;
    localparam logic [13:0] CENT_YEARS  = 14'd100;

    typedef struct packed {
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic [15:0] days_to_add;
    } gdad_in_t;

    typedef struct packed {
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [13:0] new_year;
        logic        year_overflow;
    } gdad_out_t;

    // Commands from the sequencer to the year counter
    typedef struct packed {
        logic        load;
        logic        split;
        logic        inc;
        logic [13:0] year;
    } gdad_yctl_t;

    // Days in a month (month already limited to 1..12)
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            unique case (m)
                4'd2:                      len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

>>> src/gregorian_date_add_days.sv
`default_nettype none
// Gregorian date adder: start date plus an unsigned day count.
// Input channel item_valid / item_stall / item carries one beat with the start
// day, month, year and the count of days. Output channel result_valid /
// result_stall / result carries the new date and the overflow flag.
// Out-of-range fields are first limited: month to 1..12, year to 9999,
// day to 1..length of that month.
// The walk takes one month per cycle through a single shared subtractor.
// The year is split, the day limited, then the walk runs until the result
// beat turns valid; one beat is in flight at a time, so a new item is taken
// only after the last result beat has been taken, and item_stall stays high
// from the accept until the result beat has been taken.
// A walk past December 9999 stops and returns 31 Dec 9999 with the
// overflow flag set.
// While result_stall is high the result beat holds steady and the block
// takes no new item. Reset empties the block: no result is pending and the
// input is open.
module gregorian_date_add_days (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_stall,
    input  wire gdad_pkg::gdad_in_t item,
    output logic                result_valid,
    input  wire                 result_stall,
    output gdad_pkg::gdad_out_t result
);
    import gdad_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SPLIT = 3'd1;
    localparam logic [2:0] S_CLAMP = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [15:0] rem_reg, rem_next;
    logic        ovf_reg, ovf_next;

    gdad_yctl_t  yctl;
    logic [13:0] year;
    logic        leap;
    logic        accept;
    logic [4:0]  len;
    logic [4:0]  left;
    logic [16:0] diff;
    logic [3:0]  month_in;
    logic [13:0] year_in;

    gdad_year_ctr u_year (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (yctl),
        .year  (year),
        .leap  (leap)
    );

    assign accept = item_valid && !item_stall;
    assign len    = month_days(month_reg, leap);

    // Shared unit: days left in this month, then count minus (left + 1)
    assign left = len - day_reg;
    assign diff = {1'b0, rem_reg} - ({12'd0, left} + 17'd1);

    // Limit the incoming month and year
    always_comb
    begin
        priority if (item.start_month == 4'd0)
            month_in = MONTH_JAN;
        else if (item.start_month > MONTH_DEC)
            month_in = MONTH_DEC;
        else
            month_in = item.start_month;
        year_in = (item.start_year > YEAR_MAX) ? YEAR_MAX : item.start_year;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        day_next   = day_reg;
        month_next = month_reg;
        rem_next   = rem_reg;
        ovf_next   = ovf_reg;
        yctl       = '{load: 1'b0, split: 1'b0, inc: 1'b0, year: year_in};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    day_next   = item.start_day;
                    month_next = month_in;
                    rem_next   = item.days_to_add;
                    ovf_next   = 1'b0;
                    yctl.load  = 1'b1;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                yctl.split = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                priority if (day_reg == 5'd0)
                    day_next = DAY_FIRST;
                else if (day_reg > len)
                    day_next = len;
                else
                    day_next = day_reg;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (rem_reg == 16'd0)
                begin
                    state_next = S_DONE;
                end
                else if (!diff[16])
                begin
                    // Cross into the next month
                    rem_next = diff[15:0];
                    day_next = DAY_FIRST;
                    if (month_reg == MONTH_DEC)
                    begin
                        if (year >= YEAR_MAX)
                        begin
                            ovf_next   = 1'b1;
                            day_next   = DAY_LAST_DEC;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            month_next = MONTH_JAN;
                            yctl.inc   = 1'b1;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
                else
                begin
                    // Remaining days fit in this month
                    day_next   = day_reg + rem_reg[4:0];
                    rem_next   = 16'd0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!result_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            day_reg   <= '0;
            month_reg <= '0;
            rem_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            rem_reg   <= rem_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign item_stall           = (state_reg != S_IDLE);
    assign result_valid         = (state_reg == S_DONE);
    assign result.new_day       = day_reg;
    assign result.new_month     = month_reg;
    assign result.new_year      = year;
    assign result.year_overflow = ovf_reg;

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("result pending while input open");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SPLIT))
        else $error("accepted beat did not start the walk");

    a_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (day_reg != 5'd0 && day_reg <= len))
        else $error("day outside its month during walk");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (month_reg != 4'd0 && month_reg <= MONTH_DEC))
        else $error("month out of range during walk");

    a_ovf_date: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.year_overflow) |->
            (result.new_day == DAY_LAST_DEC && result.new_month == MONTH_DEC))
        else $error("overflow result not 31 December");
`endif

endmodule

`default_nettype wire

>>> src/gdad_year_ctr.sv
`default_nettype none

module gdad_year_ctr (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire gdad_pkg::gdad_yctl_t ctl,
    output logic [13:0]          year,
    output logic                 leap
);
    import gdad_pkg::*;

    logic [13:0] year_reg;
    logic [6:0]  cent_reg;
    logic [6:0]  yoc_reg;
    logic [26:0] prod_reg;

    logic [6:0]  cent_split;
    logic [13:0] cent_base;
    logic [13:0] yoc_wide;

    // Take the quotient from the registered product, then the remainder
    always_comb
    begin
        cent_split = prod_reg[RECIP_SHIFT +: 7];
        cent_base  = 14'({7'd0, cent_split} * CENT_YEARS);
        yoc_wide   = year_reg - cent_base;
    end

    // Load, split, or advance the year
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg <= '0;
            cent_reg <= '0;
            yoc_reg  <= '0;
            prod_reg <= '0;
        end
        else if (ctl.load)
        begin
            year_reg <= ctl.year;
            prod_reg <= {13'd0, ctl.year} * {14'd0, RECIP_100};
        end
        else if (ctl.split)
        begin
            cent_reg <= cent_split;
            yoc_reg  <= yoc_wide[6:0];
        end
        else if (ctl.inc)
        begin
            year_reg <= year_reg + 14'd1;
            if (yoc_reg == CENT_LAST)
            begin
                yoc_reg  <= '0;
                cent_reg <= cent_reg + 7'd1;
            end
            else
            begin
                yoc_reg <= yoc_reg + 7'd1;
            end
        end
    end

    // Leap: divisible by 4, centuries only when divisible by 400
    assign year = year_reg;
    assign leap = (yoc_reg != 7'd0) ? (yoc_reg[1:0] == 2'd0) : (cent_reg[1:0] == 2'd0);

endmodule

`default_nettype wire
